// ===== rtl/armed_sensor_alarm_with_snooze_assert.svh =====
// Assertion macros for the armed sensor alarm block.
`ifndef ARMED_SENSOR_ALARM_WITH_SNOOZE_ASSERT_SVH
`define ARMED_SENSOR_ALARM_WITH_SNOOZE_ASSERT_SVH
`ifndef SYNTHESIS
`define ASA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("asa assertion failed");
`define ASA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("asa assertion failed");
`else
`define ASA_ASSERT(label, clk, rst_n, prop)
`define ASA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/asa_pkg.sv =====
// Shared constants and types for the armed sensor alarm block.
`timescale 1ns / 1ps
package asa_pkg;
    localparam int GROUP_COUNT_DEF    = 3;
    localparam int BITS_PER_GROUP_DEF = 8;
    localparam int TIME_WIDTH_DEF     = 48;

    localparam int GRP_ADDR_W   = 3;
    localparam int SENSOR_BITS_W = 8;
    localparam int IDX_W        = 6;
    localparam int SENSOR_IDX_W = 5;
    localparam int ARM_W        = 24;
    localparam int SEC_W        = 8;
    localparam int SNOOZE_US_W  = 28;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 24;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_ARM_MASK       = 2'd0;
    localparam t_cfg_idx CFG_SNOOZE_SECONDS = 2'd1;
    localparam t_cfg_idx CFG_SHOW_SECONDS   = 2'd2;

    localparam logic [SEC_W-1:0] SNOOZE_MAX = 8'd180;
    localparam logic [SEC_W-1:0] SNOOZE_RST = 8'd30;
    localparam logic [SEC_W-1:0] SHOW_RST   = 8'd10;
    localparam logic [SNOOZE_US_W-1:0] US_PER_SECOND = 28'd1000000;
    localparam logic [SNOOZE_US_W-1:0] SNOOZE_US_RST = 28'd30000000;
endpackage

// ===== rtl/asa_if.sv =====
// Handshake channel interfaces: sensor report in, alarm out, register write.
`timescale 1ns / 1ps
interface asa_in_if #(
    parameter int TIME_WIDTH = asa_pkg::TIME_WIDTH_DEF
);
    logic                               valid;
    logic                               ready;
    logic [asa_pkg::GRP_ADDR_W-1:0]     group_addr;
    logic [asa_pkg::SENSOR_BITS_W-1:0]  sensor_bits;
    logic [TIME_WIDTH-1:0]              now_us;
    modport source (output valid, group_addr, sensor_bits, now_us, input ready);
    modport sink (input valid, group_addr, sensor_bits, now_us, output ready);
endinterface

interface asa_out_if;
    logic                               valid;
    logic                               ready;
    logic [asa_pkg::SENSOR_IDX_W-1:0]   sensor_index;
    logic [asa_pkg::SEC_W-1:0]          display_seconds;
    logic                               last_alarm;
    modport source (output valid, sensor_index, display_seconds, last_alarm, input ready);
    modport sink (input valid, sensor_index, display_seconds, last_alarm, output ready);
endinterface

interface asa_cfg_if;
    logic                               valid;
    logic                               ready;
    asa_pkg::t_cfg_idx                  index;
    logic [asa_pkg::CFG_DATA_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/asa_alarm_core.sv =====
// Per-lane edge detect, snooze check and alarm time storage.
`timescale 1ns / 1ps
module asa_alarm_core #(
    parameter int GROUP_COUNT    = asa_pkg::GROUP_COUNT_DEF,
    parameter int BITS_PER_GROUP = asa_pkg::BITS_PER_GROUP_DEF,
    parameter int TIME_WIDTH     = asa_pkg::TIME_WIDTH_DEF,
    localparam int GW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_commit,
    input  logic [GW-1:0]                     i_grp,
    input  logic [BITS_PER_GROUP-1:0]         i_bits,
    input  logic [TIME_WIDTH-1:0]             i_now,
    input  logic [BITS_PER_GROUP-1:0]         i_arm,
    input  logic [asa_pkg::SNOOZE_US_W-1:0]   i_snooze_us,
    output logic [BITS_PER_GROUP-1:0]         o_fire
);
    logic [BITS_PER_GROUP-1:0] r_prev [GROUP_COUNT];
    // One lane per bit position; each lane holds one time per group.
    logic [TIME_WIDTH-1:0]     r_last [BITS_PER_GROUP][GROUP_COUNT];
    logic [TIME_WIDTH-1:0]     snooze_ext;
    logic [BITS_PER_GROUP-1:0] prev_cur;

    assign snooze_ext = TIME_WIDTH'(i_snooze_us);
    assign prev_cur   = r_prev[i_grp];

    always_comb begin
        logic [TIME_WIDTH-1:0] last;
        logic [TIME_WIDTH-1:0] diff;
        for (int b = 0; b < BITS_PER_GROUP; b++) begin
            last = r_last[b][i_grp];
            // Modular difference: a timestamp that runs backwards looks old.
            diff = i_now - last;
            o_fire[b] = i_bits[b] & ~prev_cur[b] & i_arm[b]
                        & ((last == '0) | (diff >= snooze_ext));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < GROUP_COUNT; g++) begin
                r_prev[g] <= '0;
                for (int b = 0; b < BITS_PER_GROUP; b++) begin
                    r_last[b][g] <= '0;
                end
            end
        end else if (i_commit) begin
            r_prev[i_grp] <= i_bits;
            for (int b = 0; b < BITS_PER_GROUP; b++) begin
                if (o_fire[b]) begin
                    r_last[b][i_grp] <= i_now;
                end
            end
        end
    end
endmodule

// ===== rtl/armed_sensor_alarm_with_snooze.sv =====
// Top level: armed sensor alarm with per-sensor snooze window.
// Each report goes from the input register through the alarm stage to the output.
// Throughput: one report per cycle while each raises at most one alarm and the
//   output is free; a report with k alarms holds the alarm stage, one per cycle.
// Reset (synchronous, active low) clears stored bits and alarm times, arm mask 0,
//   snooze 30 s, show 10 s; no clearing pass, the block takes items right away.
`timescale 1ns / 1ps
`include "armed_sensor_alarm_with_snooze_assert.svh"
module armed_sensor_alarm_with_snooze #(
    parameter int GROUP_COUNT    = asa_pkg::GROUP_COUNT_DEF,
    parameter int BITS_PER_GROUP = asa_pkg::BITS_PER_GROUP_DEF,
    parameter int TIME_WIDTH     = asa_pkg::TIME_WIDTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    asa_in_if.sink     i_in,
    asa_cfg_if.sink    i_cfg,
    asa_out_if.source  o_out
);
    localparam int GW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int PW = (BITS_PER_GROUP > 1) ? $clog2(BITS_PER_GROUP) : 1;

    // Configuration registers
    logic [asa_pkg::ARM_W-1:0]        r_arm;
    logic [asa_pkg::SEC_W-1:0]        r_show;
    logic [asa_pkg::SNOOZE_US_W-1:0]  r_snooze_us;
    logic [asa_pkg::SEC_W-1:0]        snooze_sat;

    // Input register
    logic                                  r_in_valid;
    logic [asa_pkg::GRP_ADDR_W-1:0]        r_in_grp;
    logic [asa_pkg::SENSOR_BITS_W-1:0]     r_in_bits;
    logic [TIME_WIDTH-1:0]                 r_in_now;

    // Alarm stage: pending alarms of one report, drained lowest bit first
    logic [BITS_PER_GROUP-1:0]             r_pend;
    logic [asa_pkg::GRP_ADDR_W-1:0]        r_pend_grp;

    // Output register
    logic                                  r_out_valid;
    logic [asa_pkg::SENSOR_IDX_W-1:0]      r_out_idx;
    logic [asa_pkg::SEC_W-1:0]             r_out_show;
    logic                                  r_out_last;

    logic                          in_ready;
    logic                          grp_ok;
    logic                          xfer;
    logic                          commit;
    logic                          emit;
    logic [BITS_PER_GROUP-1:0]     lowest;
    logic [BITS_PER_GROUP-1:0]     pend_after;
    logic [BITS_PER_GROUP-1:0]     arm_lane;
    logic [BITS_PER_GROUP-1:0]     fire;
    logic [PW-1:0]                 pos;

    //------------------------------------------------------------------
    // Configuration writes: always ready; snooze saturates at its max,
    // stored pre-scaled to microseconds so the compare needs no multiply.
    //------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;
    assign snooze_sat = (i_cfg.data[asa_pkg::SEC_W-1:0] > asa_pkg::SNOOZE_MAX)
                        ? asa_pkg::SNOOZE_MAX : i_cfg.data[asa_pkg::SEC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arm       <= '0;
            r_show      <= asa_pkg::SHOW_RST;
            r_snooze_us <= asa_pkg::SNOOZE_US_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                asa_pkg::CFG_ARM_MASK: begin
                    r_arm <= i_cfg.data[asa_pkg::ARM_W-1:0];
                end
                asa_pkg::CFG_SNOOZE_SECONDS: begin
                    r_snooze_us <= asa_pkg::SNOOZE_US_W'(
                        asa_pkg::SNOOZE_US_W'(snooze_sat) * asa_pkg::US_PER_SECOND);
                end
                asa_pkg::CFG_SHOW_SECONDS: begin
                    r_show <= i_cfg.data[asa_pkg::SEC_W-1:0];
                end
                default: begin
                    // unknown register index: drop the write
                end
            endcase
        end
    end

    //------------------------------------------------------------------
    // Alarm stage drain: pick the lowest pending bit whenever the output
    // register is empty or being taken.
    //------------------------------------------------------------------
    assign emit       = (r_pend != '0) && (!r_out_valid || o_out.ready);
    assign lowest     = r_pend & (~r_pend + BITS_PER_GROUP'(1));
    assign pend_after = emit ? (r_pend & ~lowest) : r_pend;

    // Hand the input item to the alarm stage once the stage drains this cycle.
    assign xfer     = r_in_valid && (pend_after == '0);
    assign grp_ok   = int'(r_in_grp) < GROUP_COUNT;
    assign commit   = xfer && grp_ok;
    assign in_ready = !r_in_valid || xfer;
    assign i_in.ready = in_ready;

    //------------------------------------------------------------------
    // Input register: hold the item until the alarm stage takes it.
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && in_ready) begin
            r_in_valid <= 1'b1;
        end else if (xfer) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_ready) begin
            r_in_grp  <= i_in.group_addr;
            r_in_bits <= i_in.sensor_bits;
            r_in_now  <= i_in.now_us;
        end
    end

    // Arm bit per lane; sensors beyond the arm mask are never armed.
    always_comb begin
        logic [asa_pkg::IDX_W-1:0] idx;
        for (int b = 0; b < BITS_PER_GROUP; b++) begin
            idx = asa_pkg::IDX_W'(int'(r_in_grp) * BITS_PER_GROUP + b);
            arm_lane[b] = (int'(idx) < asa_pkg::ARM_W) && r_arm[idx[4:0]];
        end
    end

    asa_alarm_core #(
        .GROUP_COUNT    (GROUP_COUNT),
        .BITS_PER_GROUP (BITS_PER_GROUP),
        .TIME_WIDTH     (TIME_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_commit    (commit),
        .i_grp       (r_in_grp[GW-1:0]),
        .i_bits      (r_in_bits[BITS_PER_GROUP-1:0]),
        .i_now       (r_in_now),
        .i_arm       (arm_lane),
        .i_snooze_us (r_snooze_us),
        .o_fire      (fire)
    );

    // Load a new alarm set on transfer; an invalid group loads nothing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (xfer) begin
            r_pend <= commit ? fire : '0;
        end else begin
            r_pend <= pend_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (xfer) begin
            r_pend_grp <= r_in_grp;
        end
    end

    // Position of the lowest pending bit
    always_comb begin
        pos = '0;
        for (int b = BITS_PER_GROUP - 1; b >= 0; b--) begin
            if (r_pend[b]) begin
                pos = PW'(b);
            end
        end
    end

    //------------------------------------------------------------------
    // Output register: advance on emit, drop valid once taken.
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_idx  <= asa_pkg::SENSOR_IDX_W'(int'(r_pend_grp) * BITS_PER_GROUP
                                                 + int'(pos));
            r_out_show <= r_show;
            r_out_last <= ((r_pend & ~lowest) == '0);
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.sensor_index    = r_out_idx;
    assign o_out.display_seconds = r_out_show;
    assign o_out.last_alarm      = r_out_last;

    // Each drain cycle without a new load removes exactly one pending alarm.
    `ASA_ASSERT_NEXT(a_drain_one, i_clk, i_rst_n, emit && !xfer, $countones(r_pend) == $past($countones(r_pend)) - 1)
    // An emit always leaves a valid alarm in the output register.
    `ASA_ASSERT_NEXT(a_emit_shows, i_clk, i_rst_n, emit, r_out_valid)
    // Scaled snooze never exceeds the saturated maximum.
    `ASA_ASSERT(a_snooze_range, i_clk, i_rst_n, r_snooze_us <= asa_pkg::SNOOZE_US_W'(180000000))
    // The input side only stalls while an item waits in the input register.
    `ASA_ASSERT(a_stall_held, i_clk, i_rst_n, in_ready || r_in_valid)
endmodule

// ===== bench/asa_alarm_checker.sv =====
// Scoreboard for the armed sensor alarm block: tracks reports and register writes, checks alarms.
`timescale 1ns / 1ps
module asa_alarm_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    asa_in_if    i_in,
    asa_cfg_if   i_cfg,
    asa_out_if   i_out,
    output int   o_errors,
    output int   o_pending,
    output int   o_reports,
    output int   o_ignored,
    output int   o_alarms,
    output int   o_snoozed
);
    import asa_pkg::*;

    localparam int GROUPS       = GROUP_COUNT_DEF;
    localparam int BITS         = BITS_PER_GROUP_DEF;
    localparam int SENSORS      = GROUPS * BITS;
    localparam int TW           = TIME_WIDTH_DEF;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [SENSOR_IDX_W-1:0] sensor;
        logic [SEC_W-1:0]        secs;
        logic                    last;
    } t_alarm;

    t_alarm                   due_alarms[$];
    logic [SENSOR_BITS_W-1:0] seen_bits[GROUPS];
    logic [TW-1:0]            alarm_stamp[SENSORS];
    logic [ARM_W-1:0]         armed;
    logic [SEC_W-1:0]         snooze_sec;
    logic [SEC_W-1:0]         show_s;
    int                       fail_count;
    int                       report_count;
    int                       ignored_count;
    int                       alarm_count;
    int                       snoozed_count;

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("%s", msg);
        end
    endfunction

    function automatic void apply_write(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ARM_MASK: begin
                armed = data[ARM_W-1:0];
            end
            CFG_SNOOZE_SECONDS: begin
                snooze_sec = (data[SEC_W-1:0] > SNOOZE_MAX) ? SNOOZE_MAX : data[SEC_W-1:0];
            end
            CFG_SHOW_SECONDS: begin
                show_s = data[SEC_W-1:0];
            end
            default: begin
            end
        endcase
    endfunction

    // Queue the alarms one report raises, in ascending bit order.
    function automatic void predict_alarms(logic [GRP_ADDR_W-1:0] grp,
                                           logic [SENSOR_BITS_W-1:0] bits,
                                           logic [TW-1:0] now);
        logic [SENSOR_BITS_W-1:0] rising;
        logic [TW-1:0]            window_us;
        int                       sensor;
        int                       first;
        report_count++;
        if (grp >= GROUPS) begin
            ignored_count++;
            return;
        end
        rising         = bits & ~seen_bits[grp];
        seen_bits[grp] = bits;
        window_us      = TW'(snooze_sec) * TW'(US_PER_SECOND);
        first          = due_alarms.size();
        for (int b = 0; b < BITS; b++) begin
            sensor = int'(grp) * BITS + b;
            if (!rising[b] || !armed[sensor]) begin
                continue;
            end
            // A zero stamp means never alarmed; the difference wraps at the time width.
            if (alarm_stamp[sensor] != '0 && (now - alarm_stamp[sensor]) < window_us) begin
                snoozed_count++;
                continue;
            end
            alarm_stamp[sensor] = now;
            due_alarms.push_back('{sensor: SENSOR_IDX_W'(sensor), secs: show_s, last: 1'b0});
        end
        if (due_alarms.size() > first) begin
            due_alarms[due_alarms.size()-1].last = 1'b1;
        end
    endfunction

    function automatic void check_alarm(t_alarm got);
        t_alarm want;
        if (due_alarms.size() == 0) begin
            note_failure($sformatf("unexpected alarm: sensor %0d show %0d last %0b",
                                   got.sensor, got.secs, got.last));
            return;
        end
        want = due_alarms.pop_front();
        alarm_count++;
        if (got.sensor != want.sensor || got.secs != want.secs || got.last != want.last) begin
            note_failure($sformatf(
                "alarm mismatch: expected sensor %0d show %0d last %0b, got %0d %0d %0b",
                want.sensor, want.secs, want.last, got.sensor, got.secs, got.last));
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            due_alarms.delete();
            foreach (seen_bits[g]) seen_bits[g] = '0;
            foreach (alarm_stamp[s]) alarm_stamp[s] = '0;
            armed         = '0;
            snooze_sec    = SNOOZE_RST;
            show_s        = SHOW_RST;
            fail_count    = 0;
            report_count  = 0;
            ignored_count = 0;
            alarm_count   = 0;
            snoozed_count = 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                check_alarm('{i_out.sensor_index, i_out.display_seconds, i_out.last_alarm});
            end
            if (i_cfg.valid && i_cfg.ready) begin
                apply_write(i_cfg.index, i_cfg.data);
            end
            if (i_in.valid && i_in.ready) begin
                predict_alarms(i_in.group_addr, i_in.sensor_bits, i_in.now_us);
            end
        end
        o_errors  <= fail_count;
        o_pending <= due_alarms.size();
        o_reports <= report_count;
        o_ignored <= ignored_count;
        o_alarms  <= alarm_count;
        o_snoozed <= snoozed_count;
    end
endmodule

// ===== bench/tb_armed_sensor_alarm_with_snooze.sv =====
// Testbench top for the armed sensor alarm block: stimulus, back pressure and verdict.
`timescale 1ns / 1ps
module tb_armed_sensor_alarm_with_snooze;
    import asa_pkg::*;

    localparam int       PERIOD         = 12;
    localparam int       GROUPS         = GROUP_COUNT_DEF;
    localparam int       TW             = TIME_WIDTH_DEF;
    localparam int       RANDOM_PHASES  = 5;
    localparam int       PHASE_ITEMS    = 96;
    // Leave generous room for reports that raise nothing to pass through the block.
    localparam int       SETTLE_CYCLES  = 8;
    localparam int       HOLD_CYCLES    = 300;
    localparam int       WATCHDOG_LIMIT = 4000;
    // Register index with nothing behind it; writes to it must be dropped.
    localparam t_cfg_idx CFG_SPARE_IDX  = 2'd3;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    bit            gaps_on;
    bit            hold_req;
    logic [TW-1:0] clock_us;
    int            settings_used;
    int            idle_cycles = 0;
    int            errors;
    int            pending;
    int            reports;
    int            ignored;
    int            alarms;
    int            snoozed;

    always #(PERIOD / 2) i_clk = ~i_clk;

    asa_in_if  in_ch ();
    asa_cfg_if cfg_ch ();
    asa_out_if out_ch ();

    armed_sensor_alarm_with_snooze DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    asa_alarm_checker u_alarm_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .i_cfg     (cfg_ch),
        .i_out     (out_ch),
        .o_errors  (errors),
        .o_pending (pending),
        .o_reports (reports),
        .o_ignored (ignored),
        .o_alarms  (alarms),
        .o_snoozed (snoozed)
    );

    // Offer one report; idle first at random, then hold it until the block takes it.
    task automatic send_report(input logic [GRP_ADDR_W-1:0] addr,
                               input logic [SENSOR_BITS_W-1:0] bits,
                               input logic [TW-1:0] stamp);
        while (gaps_on && $urandom_range(99) < 15) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.group_addr  <= addr;
        in_ch.sensor_bits <= bits;
        in_ch.now_us      <= stamp;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Drop valid and wait until every expected alarm is out and the pipe has drained.
    task automatic quiesce();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all three registers back to back, optionally poking the unused index too.
    // Upper data bits are random so the truncation of narrow registers gets exercised.
    task automatic program_regs(input logic [ARM_W-1:0] arm, input logic [SEC_W-1:0] snooze,
                                input logic [SEC_W-1:0] show, input bit poke_spare);
        t_cfg_idx                idx;
        logic [CFG_DATA_W-1:0]   data;
        for (int n = 0; n < 4; n++) begin
            if (n == 3 && !poke_spare) begin
                break;
            end
            case (n)
                0: begin
                    idx  = CFG_ARM_MASK;
                    data = arm;
                end
                1: begin
                    idx  = CFG_SNOOZE_SECONDS;
                    data = {16'($urandom()), snooze};
                end
                2: begin
                    idx  = CFG_SHOW_SECONDS;
                    data = {16'($urandom()), show};
                end
                default: begin
                    idx  = CFG_SPARE_IDX;
                    data = CFG_DATA_W'($urandom());
                end
            endcase
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx;
            cfg_ch.data  <= data;
            do @(posedge i_clk); while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    // Advance the sensor clock: mostly short steps that land inside snooze windows,
    // some long ones, a few backward steps, random jumps anywhere and the odd zero.
    function automatic logic [TW-1:0] next_stamp();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            clock_us = clock_us + TW'($urandom_range(4_000_000));
        end else if (pick < 85) begin
            clock_us = clock_us + TW'($urandom_range(200_000)) * 1000;
        end else if (pick < 93) begin
            clock_us = clock_us - TW'($urandom_range(300_000_000));
        end else if (pick < 99) begin
            clock_us = TW'({$urandom(), $urandom()});
        end else begin
            clock_us = '0;
        end
        return clock_us;
    endfunction

    // Mostly valid groups; the rest go to addresses the block must ignore.
    task automatic random_report();
        logic [GRP_ADDR_W-1:0] addr;
        if ($urandom_range(99) < 85) begin
            addr = GRP_ADDR_W'($urandom_range(GROUPS - 1));
        end else begin
            addr = GRP_ADDR_W'($urandom_range(7, GROUPS));
        end
        send_report(addr, SENSOR_BITS_W'($urandom_range(255)), next_stamp());
    endtask

    // Alarm receiver: random stalls, plus one long hold-off on request so the block
    // backs up and stalls its input.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                out_ch.ready <= !(gaps_on && $urandom_range(99) < 15);
            end
        end
    end

    // Watchdog: end the run if no channel moves an item for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        // Hold every input at a known value from time zero.
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.group_addr  <= '0;
        in_ch.sensor_bits <= '0;
        in_ch.now_us      <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= CFG_ARM_MASK;
        cfg_ch.data       <= '0;
        gaps_on       = 1'b1;
        hold_req      = 1'b0;
        clock_us      = '0;
        settings_used = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: nothing armed, so a full rising byte stays silent.
        send_report(3'd0, 8'hFF, TW'(1000));

        // Arm everything, saturate snooze, show zero, and poke the unused index.
        quiesce();
        program_regs('1, 8'hFF, '0, 1'b1);
        send_report(3'd0, 8'h00, TW'(2000));
        // An alarm at time zero stores zero, so the sensors still count as never alarmed.
        send_report(3'd0, 8'hFF, '0);
        send_report(3'd0, 8'h00, TW'(1));
        send_report(3'd0, 8'hFF, TW'(5));
        // Alarm at the top of the time range, then wrap to a small time: still snoozed.
        send_report(3'd1, 8'hFF, '1);
        send_report(3'd1, 8'h00, '1);
        send_report(3'd1, 8'hFF, TW'(100));
        // A time running backwards yields a huge difference and alarms again.
        send_report(3'd2, 8'hFF, TW'(500_000_000));
        send_report(3'd2, 8'h00, TW'(500_000_001));
        send_report(3'd2, 8'hFF, TW'(400_000_000));
        // Just inside the window, then exactly at its edge.
        send_report(3'd2, 8'h00, TW'(400_000_001));
        send_report(3'd2, 8'h0F, TW'(579_999_999));
        send_report(3'd2, 8'h00, TW'(579_999_999));
        send_report(3'd2, 8'h0F, TW'(580_000_000));
        // Absent groups, including the highest address, are ignored.
        send_report(3'd3, 8'hFF, TW'(600_000_000));
        send_report(3'd7, 8'hFF, TW'(600_000_000));
        send_report(3'd0, 8'h00, TW'(10));
        send_report(3'd0, 8'hA5, TW'(10));

        // Disarm all, snooze zero, longest show time.
        quiesce();
        program_regs('0, '0, 8'hFF, 1'b0);
        send_report(3'd1, 8'h00, TW'(700_000_000));
        send_report(3'd1, 8'hFF, TW'(700_000_001));

        // Random phases, each under its own register setting.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            quiesce();
            case (p)
                0: begin
                    // Every sensor armed, no snooze: dense alarms under a long output stall.
                    program_regs('1, '0, 8'hFF, 1'b0);
                    hold_req = 1'b1;
                end
                1: begin
                    program_regs(ARM_W'($urandom()), SNOOZE_MAX, '0, 1'b0);
                end
                2: begin
                    program_regs(ARM_W'($urandom()), SEC_W'($urandom_range(10, 1)),
                                 SEC_W'($urandom()), 1'b1);
                end
                3: begin
                    program_regs('1, 8'hFF, SEC_W'($urandom()), 1'b0);
                end
                default: begin
                    program_regs(ARM_W'($urandom()), SEC_W'($urandom()),
                                 SEC_W'($urandom()), 1'b1);
                end
            endcase
            // One whole phase runs with neither side idling.
            gaps_on = (p != 1);
            repeat (PHASE_ITEMS) random_report();
        end

        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d reports (%0d to absent groups), %0d alarms checked, %0d snoozed,",
                 reports, ignored, alarms, snoozed);
        $display("over %0d register settings and a %0d-cycle output hold-off.",
                 settings_used, HOLD_CYCLES);
        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/asa_pkg.sv
rtl/asa_if.sv
rtl/asa_alarm_core.sv
rtl/armed_sensor_alarm_with_snooze.sv
bench/asa_alarm_checker.sv
bench/tb_armed_sensor_alarm_with_snooze.sv
